>>> src/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Holds the chunk entry layout and the controller/datapath command and status structs.
// No dependencies.
package ffha_pkg;

	localparam int unsigned OFS_W          = 17;
	localparam int unsigned STAT_W         = 2;
	localparam int unsigned HEAP_BYTES_D   = 131072;
	localparam int unsigned ALIGN_BYTES_D  = 4;
	localparam int unsigned HEADER_BYTES_D = 16;
	localparam int unsigned MAX_CHUNKS_D   = 256;

	typedef struct packed {
		logic [OFS_W-1:0] off;
		logic [OFS_W-1:0] size;
		logic             used;
	} entry_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_BAD  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		RA_I,
		RA_I_INC,
		RA_I_DEC,
		RA_K_INC,
		RA_K_DEC
	} ra_t;

	typedef enum logic [1:0] {
		WA_I,
		WA_I_INC,
		WA_I_DEC,
		WA_K
	} wa_t;

	typedef enum logic [2:0] {
		WD_COPY,
		WD_ALLOC,
		WD_ALLOC_SPLIT,
		WD_NEW,
		WD_A,
		WD_P
	} wd_t;

	typedef enum logic [1:0] {
		K_HOLD,
		K_CNT,
		K_I,
		K_I_INC
	} kld_t;

	typedef struct packed {
		logic  load;
		logic  rnd_step;
		logic  rd_en;
		ra_t   ra;
		logic  i_inc;
		logic  cap_a;
		logic  a_merge;
		logic  cap_p;
		logic  wr_en;
		wa_t   wa;
		wd_t   wd;
		kld_t  k_ld;
		logic  k_inc;
		logic  k_dec;
		logic  cnt_inc;
		logic  cnt_dec;
		logic  res_set;
		stat_t res_code;
		logic  res_pay;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic req_zero;
		logic i_end;
		logic i_zero;
		logic i1_end;
		logic hit;
		logic rd_free;
		logic split_ok;
		logic ins_more;
		logic rem_more;
	} sts_t;

endpackage

>>> src/first_fit_heap_allocator.sv
// First-fit heap allocator, top level: controller plus datapath with the chunk table.
// Each request rounds its size, then scans the table entries in order; later entries are shifted
// on a split or merge (a free may shift twice).
// One request at a time; busy stays high until done pulses with the result.
// The receiver cannot stall: payload_offset and status are valid in the done cycle.
// Reset restores one free chunk over the whole heap at once, with no clearing pass.
module first_fit_heap_allocator #(
	parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_D,
	parameter int unsigned ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_D,
	parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_D,
	parameter int unsigned MAX_CHUNKS   = ffha_pkg::MAX_CHUNKS_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [ffha_pkg::OFS_W-1:0]   alloc_bytes,
	input  logic [ffha_pkg::OFS_W-1:0]   free_offset,
	output logic                         done,
	output logic [ffha_pkg::OFS_W-1:0]   payload_offset,
	output logic [ffha_pkg::STAT_W-1:0]  status
);

	ffha_pkg::cmd_t cmd;
	ffha_pkg::sts_t sts;

	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	ffha_dp #(
		.HEAP_BYTES   (HEAP_BYTES),
		.ALIGN_BYTES  (ALIGN_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_CHUNKS   (MAX_CHUNKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.alloc_bytes    (alloc_bytes),
		.free_offset    (free_offset),
		.payload_offset (payload_offset),
		.status         (status)
	);

endmodule

>>> src/ffha_dp.sv
// Datapath of the first-fit heap allocator: chunk table memory, indexes, size rounding.
// Executes commands from ffha_ctrl and reports status flags back.
// Depends on ffha_pkg.
module ffha_dp #(
	parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_D,
	parameter int unsigned ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_D,
	parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_D,
	parameter int unsigned MAX_CHUNKS   = ffha_pkg::MAX_CHUNKS_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffha_pkg::cmd_t               cmd,
	output ffha_pkg::sts_t               sts,
	input  logic                         req_type,
	input  logic [ffha_pkg::OFS_W-1:0]   alloc_bytes,
	input  logic [ffha_pkg::OFS_W-1:0]   free_offset,
	output logic [ffha_pkg::OFS_W-1:0]   payload_offset,
	output logic [ffha_pkg::STAT_W-1:0]  status
);

	localparam int unsigned OW  = ffha_pkg::OFS_W;
	localparam int unsigned AW  = $clog2(MAX_CHUNKS);
	localparam int unsigned CW  = $clog2(MAX_CHUNKS + 1);
	localparam int unsigned VW  = OW + 1;
	localparam int unsigned LW  = $clog2(ALIGN_BYTES);
	localparam int unsigned SH  = VW + LW;
	localparam int unsigned PW  = 2 * VW + 2;
	localparam longint unsigned RECIP =
		((longint'(1) << SH) + longint'(ALIGN_BYTES) - 1) / longint'(ALIGN_BYTES);
	localparam int unsigned STAT_W_L = ffha_pkg::STAT_W;

	ffha_pkg::entry_t mem [MAX_CHUNKS];

	logic             typ_q;
	logic [OW-1:0]    fo_q;
	logic [VW-1:0]    val_q;
	logic [VW-1:0]    q_q;
	logic [CW-1:0]    i_q, k_q, cnt_q;
	ffha_pkg::entry_t a_q, p_q, rd_q, rd_w;
	logic             e0_q, rinit_q;
	logic [OW-1:0]    pay_q;
	logic [STAT_W_L-1:0] stat_q;

	logic [PW-1:0]    prod_w;
	logic [VW-1:0]    sz_w;
	logic [CW-1:0]    raddr, waddr;
	ffha_pkg::entry_t wdata;
	ffha_pkg::entry_t ent0;

	assign ent0   = '{off: '0, size: OW'(HEAP_BYTES - HEADER_BYTES), used: 1'b0};
	assign rd_w   = rinit_q ? ent0 : rd_q;
	assign prod_w = PW'(val_q) * PW'(RECIP);
	assign sz_w   = VW'(q_q * VW'(ALIGN_BYTES));

	always_comb begin
		sts.is_free  = typ_q;
		sts.req_zero = typ_q ? (fo_q == '0) : (sz_w == '0);
		sts.i_end    = (i_q == cnt_q);
		sts.i_zero   = (i_q == '0);
		sts.i1_end   = ({1'b0, i_q} + (CW+1)'(1) == {1'b0, cnt_q});
		sts.hit      = typ_q ?
			(rd_w.used && (VW'(rd_w.off) + VW'(HEADER_BYTES) == VW'(fo_q))) :
			(!rd_w.used && (VW'(rd_w.size) >= sz_w));
		sts.rd_free  = !rd_w.used;
		sts.split_ok = ((VW+1)'(a_q.size) > (VW+1)'(sz_w) + (VW+1)'(HEADER_BYTES)) &&
			(cnt_q < CW'(MAX_CHUNKS));
		sts.ins_more = ({1'b0, k_q} > {1'b0, i_q} + (CW+1)'(1));
		sts.rem_more = ({1'b0, k_q} + (CW+1)'(1) < {1'b0, cnt_q});
	end

	always_comb begin
		unique case (cmd.ra)
			ffha_pkg::RA_I_INC: raddr = i_q + CW'(1);
			ffha_pkg::RA_I_DEC: raddr = i_q - CW'(1);
			ffha_pkg::RA_K_INC: raddr = k_q + CW'(1);
			ffha_pkg::RA_K_DEC: raddr = k_q - CW'(1);
			default:            raddr = i_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wa)
			ffha_pkg::WA_I_INC: waddr = i_q + CW'(1);
			ffha_pkg::WA_I_DEC: waddr = i_q - CW'(1);
			ffha_pkg::WA_K:     waddr = k_q;
			default:            waddr = i_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wd)
			ffha_pkg::WD_ALLOC:       wdata = '{off: a_q.off, size: a_q.size, used: 1'b1};
			ffha_pkg::WD_ALLOC_SPLIT: wdata = '{off: a_q.off, size: OW'(sz_w), used: 1'b1};
			ffha_pkg::WD_NEW: wdata = '{
				off:  OW'(VW'(a_q.off) + VW'(HEADER_BYTES) + sz_w),
				size: OW'(VW'(a_q.size) - sz_w - VW'(HEADER_BYTES)),
				used: 1'b0};
			ffha_pkg::WD_A:   wdata = a_q;
			ffha_pkg::WD_P:   wdata = p_q;
			default:          wdata = rd_w;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[raddr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= CW'(1);
			e0_q    <= 1'b0;
			rinit_q <= 1'b0;
			typ_q   <= 1'b0;
			fo_q    <= '0;
			val_q   <= '0;
			q_q     <= '0;
			a_q     <= '0;
			p_q     <= '0;
			i_q     <= '0;
			k_q     <= '0;
			pay_q   <= '0;
			stat_q  <= '0;
		end else begin
			if (cmd.load) begin
				typ_q <= req_type;
				fo_q  <= free_offset;
				val_q <= VW'(alloc_bytes) + VW'(ALIGN_BYTES - 1);
				i_q   <= '0;
			end
			if (cmd.rnd_step) begin
				q_q <= VW'(prod_w >> SH);
			end
			if (cmd.i_inc) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.rd_en) begin
				rinit_q <= (raddr == '0) && !e0_q;
			end
			if (cmd.wr_en && waddr == '0) begin
				e0_q <= 1'b1;
			end
			if (cmd.cap_a) begin
				a_q <= '{off: rd_w.off, size: rd_w.size, used: 1'b0};
			end
			if (cmd.a_merge) begin
				a_q.size <= OW'(VW'(a_q.size) + VW'(HEADER_BYTES) + VW'(rd_w.size));
			end
			if (cmd.cap_p) begin
				p_q <= '{off: rd_w.off,
					size: OW'(VW'(rd_w.size) + VW'(HEADER_BYTES) + VW'(a_q.size)),
					used: 1'b0};
			end
			case (cmd.k_ld)
				ffha_pkg::K_CNT:   k_q <= cnt_q;
				ffha_pkg::K_I:     k_q <= i_q;
				ffha_pkg::K_I_INC: k_q <= i_q + CW'(1);
				default: begin
					if (cmd.k_inc) k_q <= k_q + CW'(1);
					else if (cmd.k_dec) k_q <= k_q - CW'(1);
				end
			endcase
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			else if (cmd.cnt_dec) cnt_q <= cnt_q - CW'(1);
			if (cmd.res_set) begin
				stat_q <= cmd.res_code;
				pay_q  <= cmd.res_pay ? OW'(VW'(a_q.off) + VW'(HEADER_BYTES)) : '0;
			end
		end
	end

	assign payload_offset = pay_q;
	assign status         = stat_q;

endmodule

>>> src/ffha_ctrl.sv
// Controller of the first-fit heap allocator: sequences scan, split, insert and merge steps.
// Drives ffha_dp through the command struct and reads its status flags.
// Depends on ffha_pkg.
module ffha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output ffha_pkg::cmd_t cmd,
	input  ffha_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		IDLE, ROUND, SCAN, CHK, A_WR, INS, INS_WR, F_NXT, F_NXT_CHK,
		REM, REM_WR, F_PRV, F_PRV_CHK, F_WR_A, F_WR_P
	} state_t;

	state_t state_q, state_n;
	logic   phase_q, phase_n;
	logic   done_n;

	always_comb begin
		cmd      = '0;
		state_n  = state_q;
		phase_n  = phase_q;
		done_n   = 1'b0;
		cmd.ra   = ffha_pkg::RA_I;
		cmd.wa   = ffha_pkg::WA_I;
		cmd.wd   = ffha_pkg::WD_COPY;
		cmd.k_ld = ffha_pkg::K_HOLD;
		cmd.res_code = ffha_pkg::ST_OK;
		unique case (state_q)
			IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = ROUND;
				end
			end
			ROUND: begin
				cmd.rnd_step = 1'b1;
				state_n      = SCAN;
			end
			SCAN: begin
				if (sts.req_zero || sts.i_end) begin
					cmd.res_set = 1'b1;
					if (sts.is_free)
						cmd.res_code = sts.req_zero ? ffha_pkg::ST_OK : ffha_pkg::ST_BAD;
					else
						cmd.res_code = ffha_pkg::ST_FAIL;
					done_n  = 1'b1;
					state_n = IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					state_n   = CHK;
				end
			end
			CHK: begin
				if (sts.hit) begin
					cmd.cap_a = 1'b1;
					state_n   = sts.is_free ? F_NXT : A_WR;
				end else begin
					cmd.i_inc = 1'b1;
					state_n   = SCAN;
				end
			end
			A_WR: begin
				cmd.wr_en = 1'b1;
				if (sts.split_ok) begin
					cmd.wd   = ffha_pkg::WD_ALLOC_SPLIT;
					cmd.k_ld = ffha_pkg::K_CNT;
					state_n  = INS;
				end else begin
					cmd.wd      = ffha_pkg::WD_ALLOC;
					cmd.res_set = 1'b1;
					cmd.res_pay = 1'b1;
					done_n      = 1'b1;
					state_n     = IDLE;
				end
			end
			INS: begin
				if (sts.ins_more) begin
					cmd.rd_en = 1'b1;
					cmd.ra    = ffha_pkg::RA_K_DEC;
					state_n   = INS_WR;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wa      = ffha_pkg::WA_I_INC;
					cmd.wd      = ffha_pkg::WD_NEW;
					cmd.cnt_inc = 1'b1;
					cmd.res_set = 1'b1;
					cmd.res_pay = 1'b1;
					done_n      = 1'b1;
					state_n     = IDLE;
				end
			end
			INS_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wa    = ffha_pkg::WA_K;
				cmd.k_dec = 1'b1;
				state_n   = INS;
			end
			F_NXT: begin
				if (sts.i1_end) begin
					state_n = F_PRV;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.ra    = ffha_pkg::RA_I_INC;
					state_n   = F_NXT_CHK;
				end
			end
			F_NXT_CHK: begin
				if (sts.rd_free) begin
					cmd.a_merge = 1'b1;
					cmd.k_ld    = ffha_pkg::K_I_INC;
					phase_n     = 1'b0;
					state_n     = REM;
				end else begin
					state_n = F_PRV;
				end
			end
			REM: begin
				if (sts.rem_more) begin
					cmd.rd_en = 1'b1;
					cmd.ra    = ffha_pkg::RA_K_INC;
					state_n   = REM_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					if (phase_q) begin
						cmd.res_set = 1'b1;
						done_n      = 1'b1;
						state_n     = IDLE;
					end else begin
						state_n = F_PRV;
					end
				end
			end
			REM_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wa    = ffha_pkg::WA_K;
				cmd.k_inc = 1'b1;
				state_n   = REM;
			end
			F_PRV: begin
				if (sts.i_zero) begin
					state_n = F_WR_A;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.ra    = ffha_pkg::RA_I_DEC;
					state_n   = F_PRV_CHK;
				end
			end
			F_PRV_CHK: begin
				if (sts.rd_free) begin
					cmd.cap_p = 1'b1;
					state_n   = F_WR_P;
				end else begin
					state_n = F_WR_A;
				end
			end
			F_WR_A: begin
				cmd.wr_en   = 1'b1;
				cmd.wd      = ffha_pkg::WD_A;
				cmd.res_set = 1'b1;
				done_n      = 1'b1;
				state_n     = IDLE;
			end
			F_WR_P: begin
				cmd.wr_en = 1'b1;
				cmd.wa    = ffha_pkg::WA_I_DEC;
				cmd.wd    = ffha_pkg::WD_P;
				cmd.k_ld  = ffha_pkg::K_I;
				phase_n   = 1'b1;
				state_n   = REM;
			end
			default: state_n = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			phase_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
			done    <= done_n;
		end
	end

	assign busy = (state_q != IDLE);

endmodule

>>> verif/tb_first_fit_heap_allocator.sv
// Testbench for first_fit_heap_allocator: directed table of requests, a table fill and drain, then random
// allocate/free traffic, each result checked against a chunk-table predictor.
// Depends on ffha_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;

	localparam int unsigned OW     = ffha_pkg::OFS_W;
	localparam int unsigned SW     = ffha_pkg::STAT_W;
	localparam int unsigned HEAP   = ffha_pkg::HEAP_BYTES_D;
	localparam int unsigned ALIGN  = ffha_pkg::ALIGN_BYTES_D;
	localparam int unsigned HDR    = ffha_pkg::HEADER_BYTES_D;
	localparam int unsigned NCHUNK = ffha_pkg::MAX_CHUNKS_D;
	localparam int unsigned WDOG   = 20000;
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic [OW-1:0]   pay;
		ffha_pkg::stat_t st;
		logic            chk;
	} answer_t;

	typedef struct {
		logic            kind;
		logic [OW-1:0]   nbytes;
		logic [OW-1:0]   foff;
		logic            known;
		logic [OW-1:0]   pay;
		ffha_pkg::stat_t st;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic          req_type;
	logic [OW-1:0] alloc_bytes;
	logic [OW-1:0] free_offset;
	logic          done;
	logic [OW-1:0] payload_offset;
	logic [SW-1:0] status;

	int unsigned chunk_off [NCHUNK];
	int unsigned chunk_len [NCHUNK];
	bit          chunk_used[NCHUNK];
	int unsigned chunk_cnt;

	answer_t     pending_answers[$];
	int unsigned live_offsets[$];
	int unsigned errors;
	int unsigned idle_cnt;
	int unsigned send_idle_pct;
	bit          accepted;

	first_fit_heap_allocator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .alloc_bytes(alloc_bytes), .free_offset(free_offset),
		.done(done), .payload_offset(payload_offset), .status(status)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic void heap_reset();
		chunk_cnt = 1;
		chunk_off[0] = 0;
		chunk_len[0] = HEAP - HDR;
		chunk_used[0] = 0;
	endfunction

	function automatic void drop_chunk(int unsigned pos);
		for (int unsigned k = pos; k + 1 < chunk_cnt; k++) begin
			chunk_off[k] = chunk_off[k+1];
			chunk_len[k] = chunk_len[k+1];
			chunk_used[k] = chunk_used[k+1];
		end
		chunk_cnt--;
	endfunction

	function automatic answer_t heap_apply(logic kind, int unsigned nbytes, int unsigned foff);
		answer_t a;
		int unsigned sz;
		int unsigned i;
		a.pay = '0;
		a.st = ffha_pkg::ST_OK;
		a.chk = 1'b1;
		if (kind == REQ_ALLOC) begin
			sz = ((nbytes + ALIGN - 1) / ALIGN) * ALIGN;
			a.st = ffha_pkg::ST_FAIL;
			if (sz != 0) begin
				for (i = 0; i < chunk_cnt; i++)
					if (!chunk_used[i] && chunk_len[i] >= sz) break;
				if (i < chunk_cnt) begin
					chunk_used[i] = 1;
					if (chunk_len[i] > sz + HDR && chunk_cnt < NCHUNK) begin
						for (int unsigned k = chunk_cnt; k > i + 1; k--) begin
							chunk_off[k] = chunk_off[k-1];
							chunk_len[k] = chunk_len[k-1];
							chunk_used[k] = chunk_used[k-1];
						end
						chunk_off[i+1] = chunk_off[i] + HDR + sz;
						chunk_len[i+1] = chunk_len[i] - sz - HDR;
						chunk_used[i+1] = 0;
						chunk_len[i] = sz;
						chunk_cnt++;
					end
					a.pay = OW'(chunk_off[i] + HDR);
					a.st = ffha_pkg::ST_OK;
				end
			end
		end else if (foff != 0) begin
			for (i = 0; i < chunk_cnt; i++)
				if (chunk_used[i] && chunk_off[i] + HDR == foff) break;
			if (i < chunk_cnt) begin
				chunk_used[i] = 0;
				if (i + 1 < chunk_cnt && !chunk_used[i+1]) begin
					chunk_len[i] += HDR + chunk_len[i+1];
					drop_chunk(i + 1);
				end
				if (i > 0 && !chunk_used[i-1]) begin
					chunk_len[i-1] += HDR + chunk_len[i];
					drop_chunk(i);
				end
			end else begin
				a.st = ffha_pkg::ST_BAD;
			end
		end
		return a;
	endfunction

	always @(posedge clk) begin
		answer_t e;
		if (done) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result pay=%0d status=%0d", $time,
					payload_offset, status);
				errors++;
			end else begin
				e = pending_answers.pop_front();
				if (e.chk && payload_offset !== e.pay) begin
					$display("%0t: payload_offset expected %0d actual %0d", $time,
						e.pay, payload_offset);
					errors++;
				end
				if (e.chk && status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || accepted || done) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic issue(logic kind, int unsigned nbytes, int unsigned foff,
		bit known, int unsigned kpay, ffha_pkg::stat_t kst);
		answer_t a;
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		start <= 1'b1;
		req_type <= kind;
		alloc_bytes <= OW'(nbytes);
		free_offset <= OW'(foff);
		do @(posedge clk); while (busy);
		accepted = 1'b1;
		a = heap_apply(kind, nbytes, foff);
		if (kind == REQ_ALLOC && a.st == ffha_pkg::ST_OK) live_offsets.push_back(a.pay);
		if (kind == REQ_FREE && a.st == ffha_pkg::ST_OK && foff != 0)
			foreach (live_offsets[j]) if (live_offsets[j] == foff) begin
				live_offsets.delete(j);
				break;
			end
		if (known && (a.pay != kpay || a.st != kst)) begin
			$display("%0t: table row disagrees, expected pay=%0d st=%0d", $time, kpay, kst);
			errors++;
		end
		pending_answers.push_back(a);
		start <= 1'b0;
		@(posedge clk);
		accepted = 1'b0;
	endtask

	task automatic random_request();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50 || live_offsets.size() == 0) begin
			case ($urandom_range(9))
				0: issue(REQ_ALLOC, $urandom_range(131071), $urandom, 0, 0, ffha_pkg::ST_OK);
				1: issue(REQ_ALLOC, $urandom_range(8), $urandom, 0, 0, ffha_pkg::ST_OK);
				2, 3: issue(REQ_ALLOC, $urandom_range(16384), $urandom, 0, 0, ffha_pkg::ST_OK);
				default: issue(REQ_ALLOC, $urandom_range(1024), $urandom, 0, 0,
					ffha_pkg::ST_OK);
			endcase
		end else if (r < 90) begin
			issue(REQ_FREE, $urandom, live_offsets[$urandom_range(live_offsets.size()-1)],
				0, 0, ffha_pkg::ST_OK);
		end else begin
			issue(REQ_FREE, $urandom, $urandom_range(131071), 0, 0, ffha_pkg::ST_OK);
		end
	endtask

	row_t rows[$];

	initial begin
		errors = 0;
		idle_cnt = 0;
		accepted = 0;
		send_idle_pct = 0;
		start = 0;
		req_type = 0;
		alloc_bytes = 0;
		free_offset = 0;
		heap_reset();
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		rows = '{
			'{REQ_ALLOC, 0, 0, 1, 0, ffha_pkg::ST_FAIL},
			'{REQ_FREE, 0, 0, 1, 0, ffha_pkg::ST_OK},
			'{REQ_FREE, 0, 16, 1, 0, ffha_pkg::ST_BAD},
			'{REQ_ALLOC, 131071, 0, 1, 0, ffha_pkg::ST_FAIL},
			'{REQ_ALLOC, 131056, 0, 1, 16, ffha_pkg::ST_OK},
			'{REQ_ALLOC, 1, 0, 1, 0, ffha_pkg::ST_FAIL},
			'{REQ_FREE, 0, 16, 1, 0, ffha_pkg::ST_OK},
			'{REQ_ALLOC, 1, 0, 1, 16, ffha_pkg::ST_OK},
			'{REQ_ALLOC, 5, 0, 1, 36, ffha_pkg::ST_OK},
			'{REQ_ALLOC, 100, 0, 0, 0, ffha_pkg::ST_OK},
			'{REQ_FREE, 0, 36, 0, 0, ffha_pkg::ST_OK},
			'{REQ_FREE, 0, 36, 1, 0, ffha_pkg::ST_BAD},
			'{REQ_ALLOC, 3, 0, 0, 0, ffha_pkg::ST_OK},
			'{REQ_FREE, 0, 17, 1, 0, ffha_pkg::ST_BAD},
			'{REQ_FREE, 0, 131071, 1, 0, ffha_pkg::ST_BAD},
			'{REQ_FREE, 131071, 16, 0, 0, ffha_pkg::ST_OK},
			'{REQ_FREE, 0, 36, 0, 0, ffha_pkg::ST_OK},
			'{REQ_ALLOC, 120, 0, 0, 0, ffha_pkg::ST_OK},
			'{REQ_ALLOC, 4, 131071, 0, 0, ffha_pkg::ST_OK}
		};
		foreach (rows[n])
			issue(rows[n].kind, rows[n].nbytes, rows[n].foff, rows[n].known,
				rows[n].pay, rows[n].st);

		// fill the table to its limit, then drain it
		for (int n = 0; n < 270; n++) issue(REQ_ALLOC, 4, 0, 0, 0, ffha_pkg::ST_OK);
		while (live_offsets.size() > 0)
			issue(REQ_FREE, 0, live_offsets[$urandom_range(live_offsets.size()-1)],
				0, 0, ffha_pkg::ST_OK);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 88 : (ph == 3) ? 33 : 0;
			for (int n = 0; n < 150; n++) random_request();
		end

		while (pending_answers.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

>>> files.f
src/ffha_pkg.sv
src/ffha_dp.sv
src/ffha_ctrl.sv
src/first_fit_heap_allocator.sv
verif/tb_first_fit_heap_allocator.sv
